// ===== sv/hbbc_pkg.sv =====
// Shared types, codes and sizes of the hashed block buffer cache.
package hbbc_pkg;
    localparam int BUFFERS = 32;
    localparam int BUCKETS = 13;
    localparam int IDX_W   = $clog2(BUFFERS);
    localparam int BKT_W   = 4;
    localparam int CNT_W   = IDX_W + 1;
    localparam int BLK_W   = 24;

    // floor(blk / BUCKETS) == (blk * BKT_RECIP) >> BKT_SHIFT for every 24-bit blk
    localparam int               BKT_RECIP_W = 25;
    localparam logic [24:0]      BKT_RECIP   = 25'd20648882;
    localparam int               BKT_SHIFT   = 28;

    typedef enum logic [1:0] {
        ACT_GET     = 2'd0,
        ACT_RELEASE = 2'd1,
        ACT_PIN     = 2'd2,
        ACT_UNPIN   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NO_FREE   = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_RSVD      = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]       dev;
        logic [BLK_W-1:0] blk;
        logic [7:0]       refs;
        logic [31:0]      use_time;
        logic             valid;
        logic [BKT_W-1:0] bucket;
        logic [31:0]      order;
    } entry_t;

    localparam int REC_W = $bits(entry_t);
endpackage

// ===== sv/hbbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hbbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== sv/hashed_block_buffer_cache.sv =====
// Hashed block buffer cache tag store: top level.
//
// Input channel s_*: one request per transfer (get, release, pin, unpin).
// Result channel m_*: exactly one result per request, in request order.
// All per-buffer tags live in one RAM (one record per buffer, registered
// read). A get first reduces block_number mod 13 with a reciprocal
// multiply (quotient, then remainder), then streams every record through
// the compare logic once, re-reads the chosen record, writes it back and
// loads the output register; if there is no hit and no free buffer, it
// loads a no-free status without a write. Release, pin and unpin read,
// modify and write one record, then load the output register. One request
// is in work at a time; the next may be accepted while a result still
// waits in the output register.
// After reset the RAM is swept once, one record per cycle, to load the
// reset tags; no request is accepted during the sweep.
// When the receiver stalls, the result holds in the output register and
// a finished second request waits until that register frees.
module hashed_block_buffer_cache (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [7:0]  s_device,
    input  logic [23:0] s_block_number,
    input  logic [4:0]  s_buffer_index,
    input  logic [31:0] s_current_tick,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_result_index,
    output logic        m_hit,
    output logic        m_need_fill,
    output logic [1:0]  m_status
);
    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_MOD    = 7'b0000100,
        ST_SCAN   = 7'b0001000,
        ST_FETCH  = 7'b0010000,
        ST_MODIFY = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    localparam int BW = hbbc_pkg::BLK_W;
    localparam int IW = hbbc_pkg::IDX_W;
    localparam int CW = hbbc_pkg::CNT_W;
    localparam int KW = hbbc_pkg::BKT_W;
    localparam int PW = BW + hbbc_pkg::BKT_RECIP_W;
    localparam int QW = PW - hbbc_pkg::BKT_SHIFT;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [1:0]  act_reg, act_next;
    logic [7:0]  dev_reg, dev_next;
    logic [BW-1:0] blk_reg, blk_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [4:0]  bidx_reg, bidx_next;
    logic [31:0] tick_reg, tick_next;
    logic [KW:0] home_reg, home_next;

    logic          hf_reg, hf_next;
    logic [IW-1:0] hidx_reg, hidx_next;
    logic [31:0]   hord_reg, hord_next;
    logic          vf_reg, vf_next;
    logic [IW-1:0] vidx_reg, vidx_next;
    logic [KW:0]   vd_reg, vd_next;
    logic [31:0]   vt_reg, vt_next;
    logic [31:0]   vo_reg, vo_next;

    logic [31:0] ictr_reg, ictr_next;

    logic [4:0] ridx_reg, ridx_next;
    logic       rhit_reg, rhit_next;
    logic       rfill_reg, rfill_next;
    logic [1:0] rstat_reg, rstat_next;

    logic       m_valid_reg, m_valid_next;
    logic [4:0] m_idx_reg, m_idx_next;
    logic       m_hit_reg, m_hit_next;
    logic       m_fill_reg, m_fill_next;
    logic [1:0] m_stat_reg, m_stat_next;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    hbbc_pkg::entry_t wrec, rrec;
    logic [hbbc_pkg::REC_W-1:0] rdata;

    hbbc_ram #(.WIDTH(hbbc_pkg::REC_W), .DEPTH(hbbc_pkg::BUFFERS)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wrec),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rrec = hbbc_pkg::entry_t'(rdata);

    logic          accept;
    logic [PW-1:0] mod_prod;
    logic [BW-1:0] mod_rem;
    logic [KW:0]   bkt_gap;
    logic          is_match, is_free, better;
    logic [IW-1:0] prev_idx;
    logic          in_range;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign prev_idx = IW'(cnt_reg - CW'(1));
    assign in_range = ({27'd0, bidx_reg} < 32'(hbbc_pkg::BUFFERS));
    assign mod_prod = {{hbbc_pkg::BKT_RECIP_W{1'b0}}, blk_reg}
                      * {{BW{1'b0}}, hbbc_pkg::BKT_RECIP};
    assign mod_rem  = blk_reg - (BW'(quo_reg) * BW'(hbbc_pkg::BUCKETS));

    always_comb begin
        is_match = ({1'b0, rrec.bucket} == home_reg) && (rrec.dev == dev_reg)
                   && (rrec.blk == blk_reg);
        is_free  = (rrec.refs == 8'd0);
        if ({1'b0, rrec.bucket} >= home_reg) begin
            bkt_gap = {1'b0, rrec.bucket} - home_reg;
        end else begin
            bkt_gap = {1'b0, rrec.bucket} + (KW+1)'(hbbc_pkg::BUCKETS) - home_reg;
        end
        better = !vf_reg || (bkt_gap < vd_reg)
                 || ((bkt_gap == vd_reg) && ((rrec.use_time < vt_reg)
                 || ((rrec.use_time == vt_reg) && (rrec.order > vo_reg))));
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        act_next     = act_reg;
        dev_next     = dev_reg;
        blk_next     = blk_reg;
        quo_next     = quo_reg;
        bidx_next    = bidx_reg;
        tick_next    = tick_reg;
        home_next    = home_reg;
        hf_next      = hf_reg;
        hidx_next    = hidx_reg;
        hord_next    = hord_reg;
        vf_next      = vf_reg;
        vidx_next    = vidx_reg;
        vd_next      = vd_reg;
        vt_next      = vt_reg;
        vo_next      = vo_reg;
        ictr_next    = ictr_reg;
        ridx_next    = ridx_reg;
        rhit_next    = rhit_reg;
        rfill_next   = rfill_reg;
        rstat_next   = rstat_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_idx_next   = m_idx_reg;
        m_hit_next   = m_hit_reg;
        m_fill_next  = m_fill_reg;
        m_stat_next  = m_stat_reg;
        we           = 1'b0;
        waddr        = cnt_reg[IW-1:0];
        wrec         = rrec;
        raddr        = cnt_reg[IW-1:0];

        case (state_reg)
            ST_CLEAR: begin
                we         = 1'b1;
                wrec       = '0;
                wrec.order = 32'(cnt_reg[IW-1:0]);
                cnt_next   = cnt_reg + CW'(1);
                if (cnt_reg == CW'(hbbc_pkg::BUFFERS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    act_next  = s_action;
                    dev_next  = s_device;
                    blk_next  = s_block_number;
                    bidx_next = s_buffer_index;
                    tick_next = s_current_tick;
                    home_next = '0;
                    cnt_next  = '0;
                    hf_next   = 1'b0;
                    vf_next   = 1'b0;
                    rhit_next  = 1'b0;
                    rfill_next = 1'b0;
                    rstat_next = hbbc_pkg::STAT_OK;
                    ridx_next  = s_buffer_index;
                    if (s_action == hbbc_pkg::ACT_GET) begin
                        state_next = ST_MOD;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_MOD: begin
                // quotient first, remainder from it in the next cycle
                if (cnt_reg == '0) begin
                    quo_next = mod_prod[PW-1:hbbc_pkg::BKT_SHIFT];
                    cnt_next = CW'(1);
                end else begin
                    home_next  = (KW+1)'(mod_rem);
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                raddr    = cnt_reg[IW-1:0];
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg != '0) begin
                    if (is_match && (!hf_reg || rrec.order > hord_reg)) begin
                        hf_next   = 1'b1;
                        hidx_next = prev_idx;
                        hord_next = rrec.order;
                    end
                    if (is_free && better) begin
                        vf_next   = 1'b1;
                        vidx_next = prev_idx;
                        vd_next   = bkt_gap;
                        vt_next   = rrec.use_time;
                        vo_next   = rrec.order;
                    end
                end
                if (cnt_reg == CW'(hbbc_pkg::BUFFERS)) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (act_reg != hbbc_pkg::ACT_GET) begin
                    raddr = bidx_reg[IW-1:0];
                    state_next = in_range ? ST_MODIFY : ST_DONE;
                end else if (hf_reg || vf_next) begin
                    raddr = hf_reg ? hidx_reg : vidx_reg;
                    state_next = ST_MODIFY;
                end else begin
                    ridx_next  = '0;
                    rstat_next = hbbc_pkg::STAT_NO_FREE;
                    state_next = ST_DONE;
                end
            end
            ST_MODIFY: begin
                we = 1'b1;
                state_next = ST_DONE;
                if (act_reg == hbbc_pkg::ACT_GET) begin
                    wrec.use_time = tick_reg;
                    wrec.valid    = 1'b1;
                    if (hf_reg) begin
                        waddr      = hidx_reg;
                        ridx_next  = 5'(hidx_reg);
                        rhit_next  = 1'b1;
                        rfill_next = !rrec.valid;
                        if (rrec.refs != 8'hFF) begin
                            wrec.refs = rrec.refs + 8'd1;
                        end
                    end else begin
                        waddr      = vidx_reg;
                        ridx_next  = 5'(vidx_reg);
                        rfill_next = 1'b1;
                        wrec.dev   = dev_reg;
                        wrec.blk   = blk_reg;
                        wrec.refs  = 8'd1;
                        // victim from another bucket moves home as newest member
                        if (vd_reg != '0) begin
                            wrec.bucket = KW'(home_reg);
                            wrec.order  = ictr_reg;
                            ictr_next   = ictr_reg + 32'd1;
                        end
                    end
                end else begin
                    waddr = bidx_reg[IW-1:0];
                    if (act_reg == hbbc_pkg::ACT_PIN) begin
                        if (rrec.refs != 8'hFF) begin
                            wrec.refs = rrec.refs + 8'd1;
                        end
                    end else begin
                        if (rrec.refs == 8'd0) begin
                            rstat_next = hbbc_pkg::STAT_UNDERFLOW;
                        end else begin
                            wrec.refs = rrec.refs - 8'd1;
                        end
                        if (act_reg == hbbc_pkg::ACT_RELEASE) begin
                            wrec.use_time = tick_reg;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_idx_next   = ridx_reg;
                    m_hit_next   = rhit_reg;
                    m_fill_next  = rfill_reg;
                    m_stat_next  = rstat_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            ictr_reg    <= 32'(hbbc_pkg::BUFFERS);
            m_valid_reg <= 1'b0;
            hf_reg      <= 1'b0;
            vf_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            ictr_reg    <= ictr_next;
            m_valid_reg <= m_valid_next;
            hf_reg      <= hf_next;
            vf_reg      <= vf_next;
        end
        act_reg    <= act_next;
        dev_reg    <= dev_next;
        blk_reg    <= blk_next;
        quo_reg    <= quo_next;
        bidx_reg   <= bidx_next;
        tick_reg   <= tick_next;
        home_reg   <= home_next;
        hidx_reg   <= hidx_next;
        hord_reg   <= hord_next;
        vidx_reg   <= vidx_next;
        vd_reg     <= vd_next;
        vt_reg     <= vt_next;
        vo_reg     <= vo_next;
        ridx_reg   <= ridx_next;
        rhit_reg   <= rhit_next;
        rfill_reg  <= rfill_next;
        rstat_reg  <= rstat_next;
        m_idx_reg  <= m_idx_next;
        m_hit_reg  <= m_hit_next;
        m_fill_reg <= m_fill_next;
        m_stat_reg <= m_stat_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_result_index = m_idx_reg;
    assign m_hit          = m_hit_reg;
    assign m_need_fill    = m_fill_reg;
    assign m_status       = m_stat_reg;

    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("request accepted while another is in work");

    a_no_result_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !m_valid_reg)
        else $error("result during clearing sweep");

    a_hit_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_hit_reg) |-> (m_stat_reg == hbbc_pkg::STAT_OK))
        else $error("hit with error status");

    a_no_free_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_stat_reg == hbbc_pkg::STAT_NO_FREE)
        |-> (!m_fill_reg && m_idx_reg == '0))
        else $error("empty pool result carries a buffer");
endmodule
